[design/gdm_pkg.sv]
// ----------------------------------------------------------------------------
// Gamepad drive mapper package
// Shared widths and the request and status bundles of the iterative divider.
// ----------------------------------------------------------------------------
package gdm_pkg;

   localparam int DIV_NUM_W = 32;
   localparam int DIV_DEN_W = 16;
   localparam int DIV_QUO_W = 17;
   localparam int DIV_HI_W  = DIV_NUM_W - DIV_QUO_W;
   localparam int DIV_CNT_W = $clog2(DIV_QUO_W + 1);

   localparam logic signed [15:0] CMD_MAX  = 16'sh7FFF;
   localparam logic signed [15:0] CMD_MIN  = 16'sh8000;
   localparam logic signed [15:0] CMD_ZERO = 16'sh0000;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_QUO_W-1:0] quot;
   } div_rsp_type;

endpackage

[design/gdm_divider.sv]
// ----------------------------------------------------------------------------
// Gamepad drive mapper divider
// Restoring divider, one quotient bit per cycle. The quotient is limited to
// its width and reads as all ones when the true quotient would not fit.
// ----------------------------------------------------------------------------
module gdm_divider
   import gdm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   typedef enum logic {DV_IDLE, DV_RUN} dv_state_type;

   dv_state_type         state_ff, state_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_QUO_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;

   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;
   logic                 ge;
   logic                 ovf;

   assign trial = {rem_ff, quo_ff[DIV_QUO_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};
   assign ovf   = {{(DIV_DEN_W-DIV_HI_W){1'b0}}, div_req.num[DIV_NUM_W-1:DIV_QUO_W]}
                  >= div_req.den;

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      case (state_ff)
         DV_IDLE: begin
            if (div_req.start) begin
               den_in   = div_req.den;
               rem_in   = {{(DIV_DEN_W-DIV_HI_W){1'b0}},
                           div_req.num[DIV_NUM_W-1:DIV_QUO_W]};
               count_in = DIV_CNT_W'(DIV_QUO_W);
               if (ovf) begin
                  quo_in  = '1;
                  done_in = 1'b1;
               end else begin
                  quo_in   = div_req.num[DIV_QUO_W-1:0];
                  state_in = DV_RUN;
               end
            end
         end
         DV_RUN: begin
            rem_in   = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            quo_in   = {quo_ff[DIV_QUO_W-2:0], ge};
            count_in = count_ff - 1'b1;
            if (count_ff == DIV_CNT_W'(1)) begin
               state_in = DV_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            state_in = DV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;

endmodule

[design/gamepad_drive_mapper_top.sv]
// ----------------------------------------------------------------------------
// Gamepad drive mapper
// Turns one gamepad report into steering, throttle, tilt and lift height
// commands, with a deadzone rescale done on a shared iterative divider.
//
//   Channel   Ports   Direction   Contents
//   request   req_*   in          link flag, stick, triggers, pad buttons
//   response  rsp_*   out         steer, drive, tilt and height commands
//   config    csr_*   in          dead band register, write only
//
// A connected request takes a scale division and a deadzone division on the
// shared divider for steering, and two more when exactly one trigger is
// pressed; the deadzone division is skipped when the dead band alone decides
// the value. A disconnected request takes no division.
// One request is in work at a time; the next is taken while a response waits.
// Reset clears the tilt value and the dead band. A stalled response holds.
// ----------------------------------------------------------------------------
module gamepad_drive_mapper_top
   import gdm_pkg::*;
#(
   parameter int STICK_FULL_SCALE   = 65535,
   parameter int TRIGGER_FULL_SCALE = 1023
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [14:0]        csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_link_up,
   input  logic [15:0]        req_stick_horizontal,
   input  logic [9:0]         req_trigger_right,
   input  logic [9:0]         req_trigger_left,
   input  logic               req_pad_left,
   input  logic               req_pad_right,
   input  logic               req_pad_up,
   input  logic               req_pad_down,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_steer_cmd,
   output logic signed [15:0] rsp_drive_cmd,
   output logic signed [15:0] rsp_tilt_cmd,
   output logic signed [15:0] rsp_height_cmd
);

   typedef enum logic [1:0] {ST_IDLE, ST_SCALE, ST_ZONE, ST_OUT} state_type;
   typedef enum logic [1:0] {DRV_NONE, DRV_FWD, DRV_REV} drv_dir_type;
   typedef enum logic {SEL_STEER, SEL_DRIVE} sel_type;

   state_type          state_ff, state_in;
   sel_type            sel_ff, sel_in;
   drv_dir_type        dir_ff, dir_in;
   logic               issued_ff, issued_in;
   logic [14:0]        dead_band_ff, dead_band_in;
   logic signed [15:0] tilt_accum_ff, tilt_accum_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [15:0]        stick_ff, stick_in;
   logic [9:0]         trig_ff, trig_in;
   logic signed [15:0] v_ff, v_in;
   logic signed [15:0] steer_ff, steer_in;
   logic signed [15:0] drive_ff, drive_in;
   logic signed [15:0] tilt_item_ff, tilt_item_in;
   logic signed [15:0] height_ff, height_in;
   logic signed [15:0] rsp_steer_ff, rsp_steer_in;
   logic signed [15:0] rsp_drive_ff, rsp_drive_in;
   logic signed [15:0] rsp_tilt_ff, rsp_tilt_in;
   logic signed [15:0] rsp_height_ff, rsp_height_in;

   div_req_type        div_req;
   div_rsp_type        div_rsp;
   logic               div_start;

   logic signed [16:0] tilt_sum;
   logic signed [17:0] steer_t;
   logic signed [15:0] scale_val;
   logic [15:0]        mag;
   logic [15:0]        d;
   logic               below;
   logic               dz_full;
   logic [DIV_QUO_W-1:0] s_val;
   logic               pos;
   logic signed [15:0] zone_res;
   logic [DIV_NUM_W-1:0] stick_num;
   logic [DIV_NUM_W-1:0] trig_num;
   logic [DIV_NUM_W-1:0] zone_num;

   gdm_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign tilt_sum = {tilt_accum_ff[15], tilt_accum_ff}
                     + (req_pad_left ? 17'sd30 : -17'sd30);

   assign steer_t = $signed({1'b0, div_rsp.quot}) - 18'sd32768;

   always_comb begin
      if (sel_ff == SEL_STEER) begin
         scale_val = (steer_t > 18'sd32767) ? CMD_MAX : steer_t[15:0];
      end else if (dir_ff == DRV_FWD) begin
         scale_val = (div_rsp.quot > 17'd32767) ? CMD_MAX : $signed(div_rsp.quot[15:0]);
      end else begin
         scale_val = (div_rsp.quot >= 17'd32768) ? CMD_MIN
                     : $signed(16'd0 - div_rsp.quot[15:0]);
      end
   end

   assign mag      = v_ff[15] ? (16'd0 - v_ff) : v_ff;
   assign below    = mag < {1'b0, dead_band_ff};
   assign dz_full  = dead_band_ff == 15'h7FFF;
   assign d        = mag - {1'b0, dead_band_ff};
   assign s_val    = issued_ff ? div_rsp.quot : (below ? 17'd0 : 17'd32768);
   assign pos      = v_ff > 16'sd0;
   assign zone_res = pos ? ((s_val > 17'd32767) ? CMD_MAX : $signed(s_val[15:0]))
                     : ((s_val >= 17'd32768) ? CMD_MIN : $signed(16'd0 - s_val[15:0]));

   assign stick_num = {stick_ff, 16'd0} - {16'd0, stick_ff};
   assign trig_num  = {7'd0, trig_ff, 15'd0} - {22'd0, trig_ff};
   assign zone_num  = {1'b0, d, 15'd0} - {16'd0, d};

   always_comb begin
      div_req.start = div_start;
      if (state_ff == ST_ZONE) begin
         div_req.num = zone_num;
         div_req.den = {1'b0, 15'h7FFF - dead_band_ff};
      end else if (sel_ff == SEL_STEER) begin
         div_req.num = stick_num;
         div_req.den = DIV_DEN_W'(STICK_FULL_SCALE);
      end else begin
         div_req.num = trig_num;
         div_req.den = DIV_DEN_W'(TRIGGER_FULL_SCALE);
      end
   end

   always_comb begin
      state_in      = state_ff;
      sel_in        = sel_ff;
      dir_in        = dir_ff;
      issued_in     = issued_ff;
      dead_band_in  = csr_wr_en ? csr_wr_data : dead_band_ff;
      tilt_accum_in = tilt_accum_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      stick_in      = stick_ff;
      trig_in       = trig_ff;
      v_in          = v_ff;
      steer_in      = steer_ff;
      drive_in      = drive_ff;
      tilt_item_in  = tilt_item_ff;
      height_in     = height_ff;
      rsp_steer_in  = rsp_steer_ff;
      rsp_drive_in  = rsp_drive_ff;
      rsp_tilt_in   = rsp_tilt_ff;
      rsp_height_in = rsp_height_ff;
      div_start     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               stick_in  = req_stick_horizontal;
               sel_in    = SEL_STEER;
               issued_in = 1'b0;
               if (req_trigger_right != 10'd0 && req_trigger_left == 10'd0) begin
                  dir_in  = DRV_FWD;
                  trig_in = req_trigger_right;
               end else if (req_trigger_left != 10'd0 && req_trigger_right == 10'd0) begin
                  dir_in  = DRV_REV;
                  trig_in = req_trigger_left;
               end else begin
                  dir_in  = DRV_NONE;
                  trig_in = 10'd0;
               end
               steer_in = CMD_ZERO;
               drive_in = CMD_ZERO;
               if (req_link_up) begin
                  tilt_item_in = tilt_accum_ff;
                  if (req_pad_left || req_pad_right) begin
                     if (tilt_sum > 17'sd32767) begin
                        tilt_accum_in = CMD_MAX;
                     end else if (tilt_sum < -17'sd32768) begin
                        tilt_accum_in = CMD_MIN;
                     end else begin
                        tilt_accum_in = tilt_sum[15:0];
                     end
                     tilt_item_in = tilt_accum_in;
                  end
                  height_in = req_pad_up ? CMD_MAX : (req_pad_down ? CMD_MIN : CMD_ZERO);
                  state_in  = ST_SCALE;
               end else begin
                  tilt_item_in = CMD_ZERO;
                  height_in    = CMD_ZERO;
                  state_in     = ST_OUT;
               end
            end
         end
         ST_SCALE: begin
            if (!issued_ff) begin
               div_start = 1'b1;
               issued_in = 1'b1;
            end else if (div_rsp.done) begin
               v_in      = scale_val;
               issued_in = 1'b0;
               state_in  = ST_ZONE;
            end
         end
         ST_ZONE: begin
            if ((!issued_ff && (below || dz_full)) || (issued_ff && div_rsp.done)) begin
               issued_in = 1'b0;
               if (sel_ff == SEL_STEER) begin
                  steer_in = zone_res;
                  if (dir_ff == DRV_NONE) begin
                     state_in = ST_OUT;
                  end else begin
                     sel_in   = SEL_DRIVE;
                     state_in = ST_SCALE;
                  end
               end else begin
                  drive_in = zone_res;
                  state_in = ST_OUT;
               end
            end else if (!issued_ff) begin
               div_start = 1'b1;
               issued_in = 1'b1;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_steer_in  = steer_ff;
               rsp_drive_in  = drive_ff;
               rsp_tilt_in   = tilt_item_ff;
               rsp_height_in = height_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sel_ff        <= SEL_STEER;
         dir_ff        <= DRV_NONE;
         issued_ff     <= 1'b0;
         dead_band_ff  <= 15'd0;
         tilt_accum_ff <= CMD_ZERO;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sel_ff        <= sel_in;
         dir_ff        <= dir_in;
         issued_ff     <= issued_in;
         dead_band_ff  <= dead_band_in;
         tilt_accum_ff <= tilt_accum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      stick_ff      <= stick_in;
      trig_ff       <= trig_in;
      v_ff          <= v_in;
      steer_ff      <= steer_in;
      drive_ff      <= drive_in;
      tilt_item_ff  <= tilt_item_in;
      height_ff     <= height_in;
      rsp_steer_ff  <= rsp_steer_in;
      rsp_drive_ff  <= rsp_drive_in;
      rsp_tilt_ff   <= rsp_tilt_in;
      rsp_height_ff <= rsp_height_in;
   end

   assign req_stall      = state_ff != ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_steer_cmd  = rsp_steer_ff;
   assign rsp_drive_cmd  = rsp_drive_ff;
   assign rsp_tilt_cmd   = rsp_tilt_ff;
   assign rsp_height_cmd = rsp_height_ff;

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("response raised outside the output state");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_SCALE || state_ff == ST_ZONE) && issued_ff)
      else $error("divider finished while the sequencer was not waiting");

   a_tilt_on_accept: assert property (@(posedge clock) disable iff (reset)
      !$stable(tilt_accum_ff) |-> $past(reset) || $past(req_valid && !req_stall))
      else $error("tilt value changed without an accepted request");

endmodule
